>>> rtl/hsl_pkg.sv
// -----------------------------------------------------------------------------
// HSL to RGB converter package
// Shared defaults for the HSL to RGB color converter.
// -----------------------------------------------------------------------------
package hsl_pkg;

   // Fractional bits of the hue, saturation and lightness inputs (1.0 = 1 << FRAC_BITS)
   localparam int unsigned FRAC_BITS_DEFAULT = 16;

   // Channel lanes of the output
   localparam int unsigned NUM_CHANNELS = 3;

endpackage

>>> rtl/hsl_to_rgb_converter.sv
// Throughput: one color per clock while the result is not stalled; stages advance
// independently, so bubbles collapse and a stalled result holds while earlier stages
// keep filling.
// Reset (synchronous, active high) clears the stage valid bits only; data registers
// are not reset.
// -----------------------------------------------------------------------------
// HSL to RGB converter
// Four-stage pipeline: saturate inputs, lightness*saturation and hue ramp weights;
// q/p terms; ramp multiply per channel; blend, scale by 255 and truncate.
// -----------------------------------------------------------------------------
module hsl_to_rgb_converter
   import hsl_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FRAC_BITS:0]   req_hue,
   input  logic [FRAC_BITS:0]   req_saturation,
   input  logic [FRAC_BITS:0]   req_lightness,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue
);

   localparam int unsigned W  = FRAC_BITS + 1;       // fraction width, holds 1.0
   localparam int unsigned PW = 2 * W;               // product width
   localparam int unsigned NW = 2 * FRAC_BITS + 1;   // blended numerator, holds 1.0^2
   localparam int unsigned SW = NW + 8;              // numerator times 255

   localparam logic [W-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [W-1:0] HALF  = ONE >> 1;
   localparam logic [W-1:0] THIRD = W'((1 << FRAC_BITS) / 3);

   // Ramp weight k for a wrapped position t in 0..ONE (result within 0..ONE)
   function automatic logic [W-1:0] ramp_k(input logic [W-1:0] t);
      logic [W+2:0] t1;
      logic [W+2:0] t2;
      logic [W+2:0] t3;
      logic [W+2:0] t6;
      logic [W+2:0] one_x;
      logic [W-1:0] k;
      t1    = (W+3)'(t);
      t2    = t1 << 1;
      t3    = t2 + t1;
      t6    = t3 << 1;
      one_x = (W+3)'(ONE);
      if (t6 < one_x) begin
         k = W'(t6);
      end else if (t2 < one_x) begin
         k = ONE;
      end else if (t3 < (one_x << 1)) begin
         k = W'((one_x << 2) - t6);
      end else begin
         k = '0;
      end
      return k;
   endfunction

   // ---------------------------------------------------------------------------
   // Handshake: each stage takes new data when empty or when its successor moves
   // ---------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !s4_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: saturate fractions, l*s, wrapped ramp positions and weights
   // ---------------------------------------------------------------------------
   logic [W-1:0]  hue_sat, sat_sat, light_sat;
   logic [W:0]    red_sum;
   logic [W-1:0]  t_pos [NUM_CHANNELS];
   logic [W-1:0]  s1_l_in, s1_s_in;
   logic [PW-1:0] s1_m_in;
   logic [W-1:0]  s1_k_in [NUM_CHANNELS];

   logic [W-1:0]  s1_l_ff, s1_s_ff;
   logic [PW-1:0] s1_m_ff;
   logic [W-1:0]  s1_k_ff [NUM_CHANNELS];

   always_comb begin
      hue_sat   = (req_hue        > ONE) ? ONE : req_hue;
      sat_sat   = (req_saturation > ONE) ? ONE : req_saturation;
      light_sat = (req_lightness  > ONE) ? ONE : req_lightness;

      // red: hue + 1/3, wrapped once past 1.0
      red_sum = {1'b0, hue_sat} + {1'b0, THIRD};
      if (red_sum > {1'b0, ONE}) begin
         t_pos[0] = W'(red_sum - {1'b0, ONE});
      end else begin
         t_pos[0] = W'(red_sum);
      end
      // green: hue itself
      t_pos[1] = hue_sat;
      // blue: hue - 1/3, wrapped once below zero
      if (hue_sat < THIRD) begin
         t_pos[2] = hue_sat + (ONE - THIRD);
      end else begin
         t_pos[2] = hue_sat - THIRD;
      end

      for (int c = 0; c < NUM_CHANNELS; c++) begin
         s1_k_in[c] = ramp_k(t_pos[c]);
      end

      s1_l_in = light_sat;
      s1_s_in = sat_sat;
      s1_m_in = PW'(light_sat) * PW'(sat_sat);
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_l_ff <= s1_l_in;
         s1_s_ff <= s1_s_in;
         s1_m_ff <= s1_m_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            s1_k_ff[c] <= s1_k_in[c];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: q and p. Below half lightness l*(1+s) reduces to l + l*s exactly.
   // Zero saturation gives q = p = l, which lands on floor(l*255) downstream.
   // ---------------------------------------------------------------------------
   logic [W-1:0] ls_hi;
   logic [W:0]   q_wide;
   logic [W-1:0] s2_p_in, s2_d_in;
   logic [W-1:0] s2_p_ff, s2_d_ff;
   logic [W-1:0] s2_k_ff [NUM_CHANNELS];

   always_comb begin
      ls_hi = s1_m_ff[FRAC_BITS +: W];
      if (s1_l_ff < HALF) begin
         q_wide = {1'b0, s1_l_ff} + {1'b0, ls_hi};
      end else begin
         q_wide = {1'b0, s1_l_ff} + {1'b0, s1_s_ff} - {1'b0, ls_hi};
      end
      s2_p_in = W'(({1'b0, s1_l_ff} << 1) - q_wide);
      s2_d_in = W'(q_wide) - s2_p_in;
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_p_ff <= s2_p_in;
         s2_d_ff <= s2_d_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            s2_k_ff[c] <= s1_k_ff[c];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: (q - p) * k per channel
   // ---------------------------------------------------------------------------
   logic [W-1:0]  s3_p_ff;
   logic [PW-1:0] s3_prod_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_p_ff <= s2_p_ff;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            s3_prod_ff[c] <= PW'(s2_d_ff) * PW'(s2_k_ff[c]);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: p*ONE + prod, times 255, keep the integer byte
   // ---------------------------------------------------------------------------
   logic [NW-1:0] blend  [NUM_CHANNELS];
   logic [SW-1:0] scaled [NUM_CHANNELS];
   logic [7:0]    chan_in [NUM_CHANNELS];
   logic [7:0]    chan_ff [NUM_CHANNELS];

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         blend[c]   = (NW'(s3_p_ff) << FRAC_BITS) + NW'(s3_prod_ff[c]);
         scaled[c]  = (SW'(blend[c]) << 8) - SW'(blend[c]);
         chan_in[c] = scaled[c][2*FRAC_BITS +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_ff[c] <= chan_in[c];
         end
      end
   end

   assign rsp_valid = s4_valid_ff;
   assign rsp_red   = chan_ff[0];
   assign rsp_green = chan_ff[1];
   assign rsp_blue  = chan_ff[2];

endmodule
